>>> design/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the cache controller RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/dmwb_pkg.sv
// ============================================================================
// dmwb_pkg
// Constants and types of the direct-mapped write-back cache controller.
// ============================================================================
package dmwb_pkg;

   localparam int NUM_LINES   = 128;
   localparam int BLOCK_BYTES = 32;

   // field widths: floor of log2, also for sizes that are not powers of two
   localparam int ADDR_W   = 32;
   localparam int OFFSET_W = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int INDEX_W  = $clog2(NUM_LINES + 1) - 1;
   localparam int BLOCK_W  = ADDR_W - OFFSET_W;
   localparam int TAG_W    = BLOCK_W - INDEX_W;
   localparam int BYTES_W  = 6;

   localparam logic [BYTES_W-1:0] BLOCK_SIZE = BYTES_W'(BLOCK_BYTES);

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [BLOCK_W-1:0]  block_number;
      logic [INDEX_W-1:0]  line_index;
      logic [TAG_W-1:0]    addr_tag;
      logic                miss;
      logic                mem_read;
      logic [BYTES_W-1:0]  mem_read_bytes;
      logic                mem_write;
      logic [BYTES_W-1:0]  mem_write_bytes;
      logic                replacement;
      logic [TAG_W-1:0]    evicted_tag;
   } rsp_type;

   // one stored line: dirty flag and tag
   typedef struct packed {
      logic             dirty;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] idx;
   } rd_req_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] idx;
      entry_type          entry;
   } wr_req_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } lookup_type;

endpackage

>>> design/dmwb_line_store.sv
// ============================================================================
// dmwb_line_store
// Line state: tag/dirty memory with registered read, valid bits in flops.
// ============================================================================
module dmwb_line_store (
   input  logic                clock,
   input  logic                reset,
   input  dmwb_pkg::rd_req_type rd,
   input  dmwb_pkg::wr_req_type wr,
   output dmwb_pkg::lookup_type rd_line
);

   dmwb_pkg::entry_type            line_mem [dmwb_pkg::NUM_LINES];
   logic [dmwb_pkg::NUM_LINES-1:0] valid_ff;
   dmwb_pkg::entry_type            rd_entry_ff;
   logic                           rd_valid_ff;

   // tag/dirty array: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_mem[wr.idx] <= wr.entry;
      end
      if (rd.en) begin
         rd_entry_ff <= line_mem[rd.idx];
         rd_valid_ff <= valid_ff[rd.idx];
      end
   end

   // valid bits; reset invalidates every line at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   assign rd_line.valid = rd_valid_ff;
   assign rd_line.entry = rd_entry_ff;

endmodule

>>> design/direct_mapped_writeback_cache_ctrl.sv
// ============================================================================
// direct_mapped_writeback_cache_ctrl
// Tag/dirty controller of a 128-line, 32-byte-block write-back cache.
// ============================================================================
// Usage
//   req channel: req_valid/req_ready carry one word {cmd, address}; cmd is
//   read or write. rsp channel: rsp_valid/rsp_ready carry one result word
//   per request: address split (offset, block, index, tag), hit/miss, the
//   block fetch and write-back sizes, and the evicted tag on a replacement.
//   Timing: the accept edge reads the line memory into the lookup stage;
//   the lookup stage then compares, updates the line and loads the output
//   register at the edge where it advances.
//   Throughput: one request per cycle unless stalled. The line memory has
//   one read and one write port; a request to the line being updated in
//   the same cycle takes the updated tag/dirty through a forwarding register.
//   Stall: when rsp_ready is low and the output register is full, the
//   lookup stage holds and req_ready drops; two requests can be in flight.
//   Reset: synchronous, clears pipeline valids and all line valid bits
//   at once; no clearing pass. Tags are used only for valid lines.
// ============================================================================
`include "assert_macros.svh"

module direct_mapped_writeback_cache_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dmwb_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dmwb_pkg::rsp_type rsp_word
);

   // ---------------------------------------------------------------------
   // pipeline registers
   // ---------------------------------------------------------------------
   logic                s1_valid_ff, s1_valid_in;
   dmwb_pkg::req_type   s1_req_ff;
   logic                fwd_ff, fwd_in;        // lookup uses forwarded line
   dmwb_pkg::entry_type fwd_entry_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   dmwb_pkg::rsp_type   rsp_word_ff, rsp_word_in;

   logic                 req_fire;
   logic                 s1_adv;
   logic [dmwb_pkg::INDEX_W-1:0] req_idx;

   dmwb_pkg::rd_req_type mem_rd;
   dmwb_pkg::wr_req_type mem_wr;
   dmwb_pkg::lookup_type mem_line;

   // lookup-stage address fields
   logic [dmwb_pkg::OFFSET_W-1:0] s1_offset;
   logic [dmwb_pkg::BLOCK_W-1:0]  s1_block;
   logic [dmwb_pkg::INDEX_W-1:0]  s1_idx;
   logic [dmwb_pkg::TAG_W-1:0]    s1_tag;

   // effective line state seen by the lookup
   logic                          line_valid;
   dmwb_pkg::entry_type           line_entry;
   logic                          hit;
   logic                          evict;

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign req_idx   = req_word.address[dmwb_pkg::OFFSET_W +: dmwb_pkg::INDEX_W];

   // ---------------------------------------------------------------------
   // line store: read at accept, written when the lookup retires
   // ---------------------------------------------------------------------
   assign mem_rd.en  = req_fire;
   assign mem_rd.idx = req_idx;

   dmwb_line_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (mem_rd),
      .wr      (mem_wr),
      .rd_line (mem_line)
   );

   // ---------------------------------------------------------------------
   // lookup stage
   // ---------------------------------------------------------------------
   assign s1_offset = s1_req_ff.address[dmwb_pkg::OFFSET_W-1:0];
   assign s1_block  = s1_req_ff.address[dmwb_pkg::ADDR_W-1:dmwb_pkg::OFFSET_W];
   assign s1_idx    = s1_block[dmwb_pkg::INDEX_W-1:0];
   assign s1_tag    = s1_block[dmwb_pkg::BLOCK_W-1:dmwb_pkg::INDEX_W];

   // a forwarded line was written by the previous access, so it is valid
   assign line_valid = fwd_ff || mem_line.valid;
   assign line_entry = fwd_ff ? fwd_entry_ff : mem_line.entry;

   assign hit   = line_valid && (line_entry.tag == s1_tag);
   assign evict = !hit && line_valid;

   // every access leaves its line valid with its own tag; a write sets dirty, a read keeps it only on a hit
   always_comb begin
      mem_wr.en          = s1_adv;
      mem_wr.idx         = s1_idx;
      mem_wr.entry.tag   = s1_tag;
      mem_wr.entry.dirty = (s1_req_ff.cmd == dmwb_pkg::CMD_WRITE) ||
                           (hit && line_entry.dirty);
   end

   always_comb begin
      rsp_word_in.byte_offset     = s1_offset;
      rsp_word_in.block_number    = s1_block;
      rsp_word_in.line_index      = s1_idx;
      rsp_word_in.addr_tag        = s1_tag;
      rsp_word_in.miss            = !hit;
      rsp_word_in.mem_read        = !hit;
      rsp_word_in.mem_read_bytes  = hit ? '0 : dmwb_pkg::BLOCK_SIZE;
      rsp_word_in.replacement     = evict;
      rsp_word_in.mem_write       = evict && line_entry.dirty;
      rsp_word_in.mem_write_bytes = (evict && line_entry.dirty) ?
                                    dmwb_pkg::BLOCK_SIZE : '0;
      rsp_word_in.evicted_tag     = evict ? line_entry.tag : '0;
   end

   // ---------------------------------------------------------------------
   // next-state logic
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      fwd_in       = fwd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         // the retiring access writes this same line at this edge
         fwd_in      = s1_adv && (s1_idx == req_idx);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff    <= req_word;
         fwd_entry_ff <= mem_wr.entry;
      end
      if (s1_adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `ASSERT_SAME(a_no_accept_on_stall, s1_valid_ff && !s1_adv, !req_fire)
   `ASSERT_NEXT(a_fwd_same_line, req_fire && s1_adv && (s1_idx == req_idx), fwd_ff)
   `ASSERT_SAME(a_wb_needs_repl, rsp_valid_ff && rsp_word_ff.mem_write, rsp_word_ff.replacement)
   `ASSERT_SAME(a_hit_quiet, rsp_valid_ff && !rsp_word_ff.miss, !rsp_word_ff.mem_read && (rsp_word_ff.evicted_tag == '0))

endmodule
